[rtl/msdm_pkg.sv]
// ----------------------------------------------------------------------------
// msdm_pkg
// types, codes and segment helpers shared by the segmented data map
// ----------------------------------------------------------------------------
package msdm_pkg;

   localparam int SEGMENTS_DEF   = 2;
   localparam int BIT_DEPTH_DEF  = 1024;
   localparam int WORD_DEPTH_DEF = 256;
   localparam int NUM_TABLES     = 4;

   localparam logic [2:0] REQ_OPEN_RD = 3'd0;
   localparam logic [2:0] REQ_OPEN_WR = 3'd1;
   localparam logic [2:0] REQ_XFER    = 3'd2;
   localparam logic [2:0] REQ_LOCAL   = 3'd3;
   localparam logic [2:0] REQ_CLR     = 3'd4;

   localparam logic [1:0] TBL_COIL  = 2'd0;
   localparam logic [1:0] TBL_DISC  = 2'd1;
   localparam logic [1:0] TBL_INREG = 2'd2;
   localparam logic [1:0] TBL_HOLD  = 2'd3;

   localparam logic [1:0] ST_OK      = 2'd0;
   localparam logic [1:0] ST_ILLEGAL = 2'd1;
   localparam logic [1:0] ST_NOXFER  = 2'd2;
   localparam logic [1:0] ST_RDONLY  = 2'd3;

   localparam logic [1:0] MODE_IDLE  = 2'd0;
   localparam logic [1:0] MODE_READ  = 2'd1;
   localparam logic [1:0] MODE_WRITE = 2'd2;

   localparam int CSR_IDX_W = 8;

   typedef logic [NUM_TABLES-1:0][63:0] maps_type;

   typedef struct packed {
      logic [1:0]        n;
      logic [1:0][15:0]  st;
      logic [1:0][15:0]  ln;
      logic [1:0][16:0]  bs;
   } seg_type;

   typedef struct packed {
      logic        hit;
      logic [16:0] idx;
   } loc_type;

   typedef struct packed {
      logic [2:0]  kind;
      logic [1:0]  tbl;
      logic [15:0] addr;
      logic [15:0] qty;
      logic [15:0] data;
      logic [1:0]  stat;
      logic        hit;
      logic [16:0] idx;
   } entry_type;

   // present segments in ascending start order
   function automatic seg_type seg_sort(input logic [63:0] m, input int segs);
      seg_type     r;
      logic        p0;
      logic        p1;
      logic [16:0] b1;
      begin
         r  = '0;
         p0 = (m[31:16] != 16'd0);
         p1 = (segs > 1) && (m[63:48] != 16'd0);
         b1 = {1'b0, m[31:16]};
         if (p0 && p1) begin
            r.n = 2'd2;
            if (m[47:32] < m[15:0]) begin
               r.st[0] = m[47:32]; r.ln[0] = m[63:48]; r.bs[0] = b1;
               r.st[1] = m[15:0];  r.ln[1] = m[31:16]; r.bs[1] = 17'd0;
            end else begin
               r.st[0] = m[15:0];  r.ln[0] = m[31:16]; r.bs[0] = 17'd0;
               r.st[1] = m[47:32]; r.ln[1] = m[63:48]; r.bs[1] = b1;
            end
         end else if (p0) begin
            r.n = 2'd1;
            r.st[0] = m[15:0]; r.ln[0] = m[31:16]; r.bs[0] = 17'd0;
         end else if (p1) begin
            r.n = 2'd1;
            r.st[0] = m[47:32]; r.ln[0] = m[63:48]; r.bs[0] = b1;
         end
         return r;
      end
   endfunction

   function automatic logic covered(input seg_type s, input logic [15:0] adr,
                                    input logic [15:0] qty);
      logic [17:0] a;
      logic [17:0] q;
      logic [17:0] e;
      logic [17:0] c;
      logic        done;
      logic        res;
      begin
         a    = {2'b00, adr};
         q    = {2'b00, qty};
         done = 1'b0;
         res  = 1'b0;
         for (int k = 0; k < 2; k++) begin
            e = {2'b00, s.st[k]} + {2'b00, s.ln[k]};
            if (!done && (k < 32'(s.n))) begin
               if (a >= {2'b00, s.st[k]} && a < e) begin
                  c = e - a;
                  if (c >= q) begin
                     res  = 1'b1;
                     done = 1'b1;
                  end else begin
                     q = q - c;
                     a = a + c;
                  end
               end else if ({2'b00, s.st[k]} > a) begin
                  done = 1'b1;
               end
            end
         end
         return res;
      end
   endfunction

   function automatic loc_type locate(input seg_type s, input logic [15:0] adr);
      loc_type     r;
      logic [16:0] e;
      begin
         r = '0;
         for (int k = 1; k >= 0; k--) begin
            e = {1'b0, s.st[k]} + {1'b0, s.ln[k]};
            if ((k < 32'(s.n)) && adr >= s.st[k] && {1'b0, adr} < e) begin
               r.hit = 1'b1;
               r.idx = s.bs[k] + {1'b0, adr - s.st[k]};
            end
         end
         return r;
      end
   endfunction

endpackage

[rtl/msdm_req_if.sv]
// ----------------------------------------------------------------------------
// msdm_req_if
// request channel: valid, ready and one request
// ----------------------------------------------------------------------------
interface msdm_req_if;
   logic        valid;
   logic        ready;
   logic [2:0]  req_type;
   logic [1:0]  table_req;
   logic [15:0] address;
   logic [15:0] quantity;
   logic [15:0] data;

   modport source (output valid, req_type, table_req, address, quantity, data,
                   input ready);
   modport sink (input valid, req_type, table_req, address, quantity, data,
                 output ready);
endinterface

[rtl/msdm_rsp_if.sv]
// ----------------------------------------------------------------------------
// msdm_rsp_if
// response channel: valid, ready and one response
// ----------------------------------------------------------------------------
interface msdm_rsp_if;
   logic        valid;
   logic        ready;
   logic [1:0]  status;
   logic [15:0] read_data;
   logic        last;
   logic        changed;

   modport source (output valid, status, read_data, last, changed, input ready);
   modport sink (input valid, status, read_data, last, changed, output ready);
endinterface

[rtl/msdm_csr_if.sv]
// ----------------------------------------------------------------------------
// msdm_csr_if
// register write channel: valid, ready, register index and write data
// ----------------------------------------------------------------------------
interface msdm_csr_if;
   logic        valid;
   logic        ready;
   logic [7:0]  index;
   logic [63:0] wdata;

   modport source (output valid, index, wdata, input ready);
   modport sink (input valid, index, wdata, output ready);
endinterface

[rtl/msdm_front.sv]
// ----------------------------------------------------------------------------
// msdm_front
// accepts requests and checks open ranges and local write addresses
// ----------------------------------------------------------------------------
module msdm_front #(
   parameter int SEGMENTS = msdm_pkg::SEGMENTS_DEF
) (
   msdm_req_if.sink             req_ch,
   input  msdm_pkg::maps_type   maps,
   input  logic                 clearing,
   input  logic                 q_ready,
   output logic                 q_push,
   output msdm_pkg::entry_type  q_entry
);
   import msdm_pkg::*;

   seg_type seg;
   loc_type loc;

   assign req_ch.ready = q_ready && !clearing;
   assign q_push       = req_ch.valid && req_ch.ready;

   always_comb begin
      seg = seg_sort(maps[req_ch.table_req], SEGMENTS);
      loc = locate(seg, req_ch.address);
      q_entry      = '0;
      q_entry.kind = req_ch.req_type;
      q_entry.tbl  = req_ch.table_req;
      q_entry.addr = req_ch.address;
      q_entry.qty  = req_ch.quantity;
      q_entry.data = req_ch.data;
      q_entry.hit  = loc.hit;
      q_entry.idx  = loc.idx;
      if (req_ch.req_type == REQ_OPEN_WR &&
          (req_ch.table_req == TBL_DISC || req_ch.table_req == TBL_INREG)) begin
         q_entry.stat = ST_RDONLY;
      end else if (!covered(seg, req_ch.address, req_ch.quantity)) begin
         q_entry.stat = ST_ILLEGAL;
      end else begin
         q_entry.stat = ST_OK;
      end
   end

endmodule

[rtl/msdm_queue.sv]
// ----------------------------------------------------------------------------
// msdm_queue
// two-entry queue between request decode and execution
// ----------------------------------------------------------------------------
module msdm_queue (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push,
   input  msdm_pkg::entry_type  push_entry,
   output logic                 push_ready,
   input  logic                 pop,
   output logic                 pop_valid,
   output msdm_pkg::entry_type  pop_entry
);
   import msdm_pkg::*;

   entry_type  slot_ff [2];
   logic       wptr_ff, wptr_in;
   logic       rptr_ff, rptr_in;
   logic [1:0] cnt_ff, cnt_in;

   assign push_ready = (cnt_ff != 2'd2);
   assign pop_valid  = (cnt_ff != 2'd0);
   assign pop_entry  = slot_ff[rptr_ff];

   always_comb begin
      wptr_in = wptr_ff ^ push;
      rptr_in = rptr_ff ^ pop;
      cnt_in  = cnt_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff <= 1'b0;
         rptr_ff <= 1'b0;
         cnt_ff  <= 2'd0;
      end else begin
         wptr_ff <= wptr_in;
         rptr_ff <= rptr_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wptr_ff] <= push_entry;
      end
   end

endmodule

[rtl/msdm_back.sv]
// ----------------------------------------------------------------------------
// msdm_back
// transfer state, table memories, clearing sweep and response register
// ----------------------------------------------------------------------------
module msdm_back #(
   parameter int SEGMENTS   = msdm_pkg::SEGMENTS_DEF,
   parameter int BIT_DEPTH  = msdm_pkg::BIT_DEPTH_DEF,
   parameter int WORD_DEPTH = msdm_pkg::WORD_DEPTH_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 q_valid,
   input  msdm_pkg::entry_type  q_entry,
   output logic                 q_pop,
   input  msdm_pkg::maps_type   maps,
   output logic                 clearing,
   msdm_rsp_if.source           rsp_ch
);
   import msdm_pkg::*;

   localparam int BA        = (BIT_DEPTH > 1) ? $clog2(BIT_DEPTH) : 1;
   localparam int WA        = (WORD_DEPTH > 1) ? $clog2(WORD_DEPTH) : 1;
   localparam int CLR_DEPTH = (BIT_DEPTH > WORD_DEPTH) ? BIT_DEPTH : WORD_DEPTH;
   localparam int CW        = $clog2(CLR_DEPTH + 1);

   logic        coil_mem [BIT_DEPTH];
   logic        disc_mem [BIT_DEPTH];
   logic [15:0] inw_mem  [WORD_DEPTH];
   logic [15:0] hold_mem [WORD_DEPTH];

   logic        coil_rd_ff, disc_rd_ff;
   logic [15:0] inw_rd_ff, hold_rd_ff;

   logic [CW-1:0] clr_ff, clr_in;

   logic [1:0]  mode_ff, mode_in;
   logic [1:0]  xtbl_ff, xtbl_in;
   logic [15:0] xaddr_ff, xaddr_in;
   logic [15:0] xrem_ff, xrem_in;
   logic        dirty_ff, dirty_in;

   logic        pend_ff, pend_in;
   logic [1:0]  pstat_ff, pstat_in;
   logic        plast_ff, plast_in;
   logic        pchg_ff, pchg_in;
   logic        prd_ff, prd_in;
   logic [1:0]  ptbl_ff, ptbl_in;

   logic        ovalid_ff, ovalid_in;
   logic [1:0]  ostat_ff, ostat_in;
   logic [15:0] odata_ff, odata_in;
   logic        olast_ff, olast_in;
   logic        ochg_ff, ochg_in;

   logic        b_go;
   loc_type     xl;
   logic        wr_en;
   logic [1:0]  wr_tbl;
   logic [16:0] wr_idx;
   logic [15:0] wr_data;
   logic        rd_en;
   logic        rd_req;
   logic [16:0] rd_idx;
   logic [1:0]  rd_tbl;
   logic [1:0]  stat;
   logic        last;
   logic        rd_ok;
   logic        wr_ok;
   logic [15:0] rsel;

   assign clearing = (clr_ff != CW'(CLR_DEPTH));
   assign b_go     = pend_ff && (!ovalid_ff || rsp_ch.ready);
   assign q_pop    = q_valid && !clearing && (!pend_ff || b_go);

   assign rsp_ch.valid     = ovalid_ff;
   assign rsp_ch.status    = ostat_ff;
   assign rsp_ch.read_data = odata_ff;
   assign rsp_ch.last      = olast_ff;
   assign rsp_ch.changed   = ochg_ff;

   always_comb begin
      xl       = locate(seg_sort(maps[xtbl_ff], SEGMENTS), xaddr_ff);
      mode_in  = mode_ff;
      xtbl_in  = xtbl_ff;
      xaddr_in = xaddr_ff;
      xrem_in  = xrem_ff;
      dirty_in = dirty_ff;
      wr_en    = 1'b0;
      wr_tbl   = q_entry.tbl;
      wr_idx   = q_entry.idx;
      wr_data  = q_entry.data;
      rd_req   = 1'b0;
      rd_idx   = xl.idx;
      rd_tbl   = xtbl_ff;
      stat     = ST_OK;
      last     = 1'b0;
      case (q_entry.kind)
         REQ_OPEN_RD, REQ_OPEN_WR: begin
            stat = q_entry.stat;
            if (q_entry.stat == ST_OK) begin
               xtbl_in  = q_entry.tbl;
               xaddr_in = q_entry.addr;
               xrem_in  = q_entry.qty;
               if (q_entry.qty == 16'd0) begin
                  mode_in = MODE_IDLE;
               end else if (q_entry.kind == REQ_OPEN_RD) begin
                  mode_in = MODE_READ;
               end else begin
                  mode_in = MODE_WRITE;
               end
            end
         end
         REQ_XFER: begin
            if (mode_ff == MODE_IDLE) begin
               stat = ST_NOXFER;
            end else if (!xl.hit) begin
               stat    = ST_ILLEGAL;
               mode_in = MODE_IDLE;
            end else begin
               if (mode_ff == MODE_READ) begin
                  rd_req = 1'b1;
               end else begin
                  wr_en    = 1'b1;
                  wr_tbl   = xtbl_ff;
                  wr_idx   = xl.idx;
                  dirty_in = 1'b1;
               end
               xaddr_in = xaddr_ff + 16'd1;
               xrem_in  = xrem_ff - 16'd1;
               if (xrem_ff == 16'd1) begin
                  last    = 1'b1;
                  mode_in = MODE_IDLE;
               end
            end
         end
         REQ_LOCAL: begin
            if (q_entry.hit) begin
               wr_en = 1'b1;
            end else begin
               stat = ST_ILLEGAL;
            end
         end
         REQ_CLR: begin
            dirty_in = 1'b0;
         end
         default: begin
         end
      endcase
      if (!q_pop) begin
         mode_in  = mode_ff;
         xtbl_in  = xtbl_ff;
         xaddr_in = xaddr_ff;
         xrem_in  = xrem_ff;
         dirty_in = dirty_ff;
         wr_en    = 1'b0;
         rd_req   = 1'b0;
      end
      rd_en = q_pop;
      if (rd_tbl == TBL_COIL || rd_tbl == TBL_DISC) begin
         rd_ok = (rd_idx < 17'(BIT_DEPTH));
      end else begin
         rd_ok = (rd_idx < 17'(WORD_DEPTH));
      end
      if (wr_tbl == TBL_COIL || wr_tbl == TBL_DISC) begin
         wr_ok = (wr_idx < 17'(BIT_DEPTH));
      end else begin
         wr_ok = (wr_idx < 17'(WORD_DEPTH));
      end
   end

   always_comb begin
      pend_in  = pend_ff;
      pstat_in = pstat_ff;
      plast_in = plast_ff;
      pchg_in  = pchg_ff;
      prd_in   = prd_ff;
      ptbl_in  = ptbl_ff;
      if (b_go) begin
         pend_in = 1'b0;
      end
      if (q_pop) begin
         pend_in  = 1'b1;
         pstat_in = stat;
         plast_in = last;
         pchg_in  = dirty_in;
         prd_in   = rd_req && rd_ok;
         ptbl_in  = rd_tbl;
      end
      case (ptbl_ff)
         TBL_COIL:  rsel = {15'd0, coil_rd_ff};
         TBL_DISC:  rsel = {15'd0, disc_rd_ff};
         TBL_INREG: rsel = inw_rd_ff;
         default:   rsel = hold_rd_ff;
      endcase
      ovalid_in = ovalid_ff;
      ostat_in  = ostat_ff;
      odata_in  = odata_ff;
      olast_in  = olast_ff;
      ochg_in   = ochg_ff;
      if (rsp_ch.ready) begin
         ovalid_in = 1'b0;
      end
      if (b_go) begin
         ovalid_in = 1'b1;
         ostat_in  = pstat_ff;
         odata_in  = prd_ff ? rsel : 16'd0;
         olast_in  = plast_ff;
         ochg_in   = pchg_ff;
      end
      clr_in = clearing ? clr_ff + CW'(1) : clr_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_ff    <= '0;
         mode_ff   <= MODE_IDLE;
         xtbl_ff   <= 2'd0;
         xaddr_ff  <= 16'd0;
         xrem_ff   <= 16'd0;
         dirty_ff  <= 1'b0;
         pend_ff   <= 1'b0;
         ovalid_ff <= 1'b0;
      end else begin
         clr_ff    <= clr_in;
         mode_ff   <= mode_in;
         xtbl_ff   <= xtbl_in;
         xaddr_ff  <= xaddr_in;
         xrem_ff   <= xrem_in;
         dirty_ff  <= dirty_in;
         pend_ff   <= pend_in;
         ovalid_ff <= ovalid_in;
      end
   end

   always_ff @(posedge clock) begin
      pstat_ff <= pstat_in;
      plast_ff <= plast_in;
      pchg_ff  <= pchg_in;
      prd_ff   <= prd_in;
      ptbl_ff  <= ptbl_in;
      ostat_ff <= ostat_in;
      odata_ff <= odata_in;
      olast_ff <= olast_in;
      ochg_ff  <= ochg_in;
   end

   // table memories, cleared by the sweep after reset
   always_ff @(posedge clock) begin
      if (clearing && clr_ff < CW'(BIT_DEPTH)) begin
         coil_mem[clr_ff[BA-1:0]] <= 1'b0;
      end else if (wr_en && wr_ok && wr_tbl == TBL_COIL) begin
         coil_mem[wr_idx[BA-1:0]] <= wr_data[0];
      end
      if (rd_en) begin
         coil_rd_ff <= coil_mem[rd_idx[BA-1:0]];
      end
   end

   always_ff @(posedge clock) begin
      if (clearing && clr_ff < CW'(BIT_DEPTH)) begin
         disc_mem[clr_ff[BA-1:0]] <= 1'b0;
      end else if (wr_en && wr_ok && wr_tbl == TBL_DISC) begin
         disc_mem[wr_idx[BA-1:0]] <= wr_data[0];
      end
      if (rd_en) begin
         disc_rd_ff <= disc_mem[rd_idx[BA-1:0]];
      end
   end

   always_ff @(posedge clock) begin
      if (clearing && clr_ff < CW'(WORD_DEPTH)) begin
         inw_mem[clr_ff[WA-1:0]] <= 16'd0;
      end else if (wr_en && wr_ok && wr_tbl == TBL_INREG) begin
         inw_mem[wr_idx[WA-1:0]] <= wr_data;
      end
      if (rd_en) begin
         inw_rd_ff <= inw_mem[rd_idx[WA-1:0]];
      end
   end

   always_ff @(posedge clock) begin
      if (clearing && clr_ff < CW'(WORD_DEPTH)) begin
         hold_mem[clr_ff[WA-1:0]] <= 16'd0;
      end else if (wr_en && wr_ok && wr_tbl == TBL_HOLD) begin
         hold_mem[wr_idx[WA-1:0]] <= wr_data;
      end
      if (rd_en) begin
         hold_rd_ff <= hold_mem[rd_idx[WA-1:0]];
      end
   end

endmodule

[rtl/modbus_segmented_data_map_core.sv]
// ----------------------------------------------------------------------------
// modbus_segmented_data_map_core
// segmented coil, discrete, input and holding tables with transfer tracking
//
//   channel   direction  handshake     payload
//   req_ch    in         valid/ready   req_type table_req address quantity data
//   rsp_ch    out        valid/ready   status read_data last changed
//   csr_ch    in         valid/ready   index wdata (map registers 0..3)
//
// one request per cycle while the queue has room; responses are registered
// after reset a sweep of max(BIT_DEPTH, WORD_DEPTH) entries zeroes the tables,
// and no request is accepted until it ends; register writes are always taken
// a two-entry queue splits decode from execution; a stalled response holds
// in its output register while the queue, until full, keeps taking requests
// ----------------------------------------------------------------------------
module modbus_segmented_data_map_core #(
   parameter int SEGMENTS   = msdm_pkg::SEGMENTS_DEF,
   parameter int BIT_DEPTH  = msdm_pkg::BIT_DEPTH_DEF,
   parameter int WORD_DEPTH = msdm_pkg::WORD_DEPTH_DEF
) (
   input  logic        clock,
   input  logic        reset,
   msdm_req_if.sink    req_ch,
   msdm_rsp_if.source  rsp_ch,
   msdm_csr_if.sink    csr_ch
);
   import msdm_pkg::*;

   maps_type  maps_ff, maps_in;
   logic      clearing;
   logic      q_push, q_ready, q_pop, q_valid;
   entry_type push_entry, pop_entry;

   assign csr_ch.ready = 1'b1;

   always_comb begin
      maps_in = maps_ff;
      if (csr_ch.valid && csr_ch.index < CSR_IDX_W'(NUM_TABLES)) begin
         maps_in[csr_ch.index[1:0]] = csr_ch.wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         maps_ff <= '0;
      end else begin
         maps_ff <= maps_in;
      end
   end

   msdm_front #(.SEGMENTS(SEGMENTS)) u_front (
      .req_ch   (req_ch),
      .maps     (maps_ff),
      .clearing (clearing),
      .q_ready  (q_ready),
      .q_push   (q_push),
      .q_entry  (push_entry)
   );

   msdm_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_entry (push_entry),
      .push_ready (q_ready),
      .pop        (q_pop),
      .pop_valid  (q_valid),
      .pop_entry  (pop_entry)
   );

   msdm_back #(
      .SEGMENTS   (SEGMENTS),
      .BIT_DEPTH  (BIT_DEPTH),
      .WORD_DEPTH (WORD_DEPTH)
   ) u_back (
      .clock    (clock),
      .reset    (reset),
      .q_valid  (q_valid),
      .q_entry  (pop_entry),
      .q_pop    (q_pop),
      .maps     (maps_ff),
      .clearing (clearing),
      .rsp_ch   (rsp_ch)
   );

endmodule

[tb/tb_modbus_segmented_data_map_core.sv]
// ----------------------------------------------------------------------------
// tb_modbus_segmented_data_map_core
// self-checking bench for the segmented modbus data map: directed and random
// requests under several segment maps, with an in-bench model of the tables
// ----------------------------------------------------------------------------
module tb_modbus_segmented_data_map_core;
   import msdm_pkg::*;

   localparam int BDEPTH  = 1024;
   localparam int WDEPTH  = 256;
   localparam int WD_LIM  = 5000;

   typedef struct packed {
      logic [2:0]  kind;
      logic [1:0]  tbl;
      logic [15:0] addr;
      logic [15:0] qty;
      logic [15:0] data;
   } request_type;

   typedef struct packed {
      logic [1:0]  status;
      logic [15:0] rdata;
      logic        last;
      logic        changed;
   } response_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   msdm_req_if req_ch ();
   msdm_rsp_if rsp_ch ();
   msdm_csr_if csr_ch ();

   modbus_segmented_data_map_core dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch),
      .csr_ch (csr_ch)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // model state
   logic [63:0] map_r [4];
   logic [1:0]  m_mode;
   logic [1:0]  m_tbl;
   logic [15:0] m_addr;
   logic [15:0] m_rem;
   logic        m_dirty;
   logic        coil_m [BDEPTH];
   logic        disc_m [BDEPTH];
   logic [15:0] inreg_m [WDEPTH];
   logic [15:0] hold_m [WDEPTH];

   request_type  pending_reqs [$];
   response_type expected_rsps [$];
   int        errors = 0;
   int        idle_cycles = 0;
   bit        hold_off = 1'b0;
   int        burst_left = 0;
   int        gap_left = 0;
   logic      req_taken;

   task automatic report(input string what, input logic [31:0] got, input logic [31:0] exp);
      $display("error %0t: %s got %0h expected %0h", $time, what, got, exp);
      errors++;
   endtask

   // segment lookup in ascending start order
   function automatic void segs(input logic [1:0] t, output int n, output int st[2],
                                output int ln[2], output int bs[2]);
      int s[2];
      int l[2];
      int b[2];
      int x;
      for (int k = 0; k < 2; k++) begin
         s[k] = map_r[t][32*k +: 16];
         l[k] = map_r[t][32*k+16 +: 16];
      end
      b[0] = 0;
      b[1] = l[0];
      n = 0;
      for (int k = 0; k < 2; k++)
         if (l[k] != 0) begin
            st[n] = s[k]; ln[n] = l[k]; bs[n] = b[k]; n++;
         end
      if (n == 2 && st[1] < st[0]) begin
         x = st[0]; st[0] = st[1]; st[1] = x;
         x = ln[0]; ln[0] = ln[1]; ln[1] = x;
         x = bs[0]; bs[0] = bs[1]; bs[1] = x;
      end
   endfunction

   function automatic bit range_mapped(input logic [1:0] t, input int a, input int q);
      int n;
      int st[2];
      int ln[2];
      int bs[2];
      int c;
      segs(t, n, st, ln, bs);
      for (int k = 0; k < n; k++) begin
         if (a >= st[k] && a < st[k] + ln[k]) begin
            c = st[k] + ln[k] - a;
            if (c >= q) return 1'b1;
            q -= c;
            a += c;
         end else if (st[k] > a) return 1'b0;
      end
      return 1'b0;
   endfunction

   function automatic bit find_entry(input logic [1:0] t, input int a, output int idx);
      int n;
      int st[2];
      int ln[2];
      int bs[2];
      segs(t, n, st, ln, bs);
      idx = 0;
      for (int k = 0; k < n; k++)
         if (a >= st[k] && a < st[k] + ln[k]) begin
            idx = bs[k] + a - st[k];
            return 1'b1;
         end
      return 1'b0;
   endfunction

   function automatic logic [15:0] table_read(input logic [1:0] t, input int i);
      case (t)
         TBL_COIL:  return (i < BDEPTH) ? 16'(coil_m[i]) : 16'd0;
         TBL_DISC:  return (i < BDEPTH) ? 16'(disc_m[i]) : 16'd0;
         TBL_INREG: return (i < WDEPTH) ? inreg_m[i] : 16'd0;
         default:   return (i < WDEPTH) ? hold_m[i] : 16'd0;
      endcase
   endfunction

   function automatic void table_write(input logic [1:0] t, input int i, input logic [15:0] d);
      case (t)
         TBL_COIL:  if (i < BDEPTH) coil_m[i] = d[0];
         TBL_DISC:  if (i < BDEPTH) disc_m[i] = d[0];
         TBL_INREG: if (i < WDEPTH) inreg_m[i] = d;
         default:   if (i < WDEPTH) hold_m[i] = d;
      endcase
   endfunction

   function automatic response_type predict_map(input request_type r);
      response_type o;
      int        idx;
      o = '0;
      if (r.kind == REQ_OPEN_RD || r.kind == REQ_OPEN_WR) begin
         if (r.kind == REQ_OPEN_WR && (r.tbl == TBL_DISC || r.tbl == TBL_INREG))
            o.status = ST_RDONLY;
         else if (!range_mapped(r.tbl, r.addr, r.qty))
            o.status = ST_ILLEGAL;
         else begin
            m_tbl = r.tbl;
            m_addr = r.addr;
            m_rem = r.qty;
            m_mode = (r.qty == 0) ? MODE_IDLE :
                     (r.kind == REQ_OPEN_RD) ? MODE_READ : MODE_WRITE;
         end
      end else if (r.kind == REQ_XFER) begin
         if (m_mode == MODE_IDLE) o.status = ST_NOXFER;
         else if (!find_entry(m_tbl, m_addr, idx)) begin
            o.status = ST_ILLEGAL;
            m_mode = MODE_IDLE;
         end else begin
            if (m_mode == MODE_READ) o.rdata = table_read(m_tbl, idx);
            else begin
               table_write(m_tbl, idx, r.data);
               m_dirty = 1'b1;
            end
            m_addr++;
            m_rem--;
            if (m_rem == 0) begin
               o.last = 1'b1;
               m_mode = MODE_IDLE;
            end
         end
      end else if (r.kind == REQ_LOCAL) begin
         if (find_entry(r.tbl, r.addr, idx)) table_write(r.tbl, idx, r.data);
         else o.status = ST_ILLEGAL;
      end else if (r.kind == REQ_CLR) m_dirty = 1'b0;
      o.changed = m_dirty;
      return o;
   endfunction

   // request taken at the last rising edge
   always @(posedge clock) begin
      if (reset) req_taken <= 1'b0;
      else req_taken <= req_ch.valid && req_ch.ready;
   end

   // driver
   always @(negedge clock) begin
      if (reset) begin
         req_ch.valid     <= 1'b0;
         req_ch.req_type  <= '0;
         req_ch.table_req <= '0;
         req_ch.address   <= '0;
         req_ch.quantity  <= '0;
         req_ch.data      <= '0;
      end else if (req_ch.valid && !req_taken) begin
      end else begin
         if (burst_left == 0 && gap_left == 0) begin
            burst_left = $urandom_range(1, 40);
            gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 6);
         end
         if (pending_reqs.size() != 0 && gap_left == 0) begin
            req_ch.valid     <= 1'b1;
            req_ch.req_type  <= pending_reqs[0].kind;
            req_ch.table_req <= pending_reqs[0].tbl;
            req_ch.address   <= pending_reqs[0].addr;
            req_ch.quantity  <= pending_reqs[0].qty;
            req_ch.data      <= pending_reqs[0].data;
            void'(pending_reqs.pop_front());
            burst_left--;
         end else begin
            req_ch.valid <= 1'b0;
            if (gap_left > 0) gap_left--;
         end
      end
   end

   // receiver stall pattern
   always @(negedge clock) begin
      if (reset || hold_off) rsp_ch.ready <= 1'b0;
      else rsp_ch.ready <= ($urandom_range(0, 7) < 2) ? 1'b0 : 1'b1;
   end

   // monitor
   always @(posedge clock) begin
      request_type  r;
      response_type e;
      if (!reset) begin
         if (req_ch.valid && req_ch.ready) begin
            r = {req_ch.req_type, req_ch.table_req, req_ch.address,
                 req_ch.quantity, req_ch.data};
            expected_rsps.push_back(predict_map(r));
         end
         if (rsp_ch.valid && rsp_ch.ready) begin
            if (expected_rsps.size() == 0) report("unexpected response", 0, 0);
            else begin
               e = expected_rsps.pop_front();
               if (rsp_ch.status !== e.status)
                  report("status", 32'(rsp_ch.status), 32'(e.status));
               if (rsp_ch.read_data !== e.rdata)
                  report("read_data", 32'(rsp_ch.read_data), 32'(e.rdata));
               if (rsp_ch.last !== e.last) report("last", 32'(rsp_ch.last), 32'(e.last));
               if (rsp_ch.changed !== e.changed)
                  report("changed", 32'(rsp_ch.changed), 32'(e.changed));
            end
         end
         if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready) ||
             (csr_ch.valid && csr_ch.ready) || hold_off)
            idle_cycles <= 0;
         else idle_cycles <= idle_cycles + 1;
         if (idle_cycles > WD_LIM) begin
            $display("modbus_segmented_data_map_core: mismatch");
            $finish;
         end
      end
   end

   task automatic write_map(input int i, input logic [63:0] v);
      @(negedge clock);
      csr_ch.valid <= 1'b1;
      csr_ch.index <= 8'(i);
      csr_ch.wdata <= v;
      @(posedge clock);
      while (!csr_ch.ready) @(posedge clock);
      map_r[i] = v;
      @(negedge clock);
      csr_ch.valid <= 1'b0;
   endtask

   task automatic drain();
      while (pending_reqs.size() != 0 || expected_rsps.size() != 0 || req_ch.valid)
         @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   function automatic void push_req(input logic [2:0] k, input logic [1:0] t,
                                    input logic [15:0] a, input logic [15:0] q,
                                    input logic [15:0] d);
      request_type r;
      r = {k, t, a, q, d};
      pending_reqs.push_back(r);
   endfunction

   function automatic logic [63:0] seg_pair(input logic [15:0] s0, input logic [15:0] l0,
                                            input logic [15:0] s1, input logic [15:0] l1);
      return {l1, s1, l0, s0};
   endfunction

   // random content, mostly well formed open/transfer sequences
   function automatic void random_batch(input int count);
      int          n;
      logic [1:0]  t;
      logic [15:0] a;
      logic [15:0] q;
      n = 0;
      while (n < count) begin
         t = 2'($urandom_range(0, 3));
         case ($urandom_range(0, 9))
            0, 1, 2, 3, 4: begin
               a = 16'($urandom);
               if (map_r[t][31:16] != 0 && $urandom_range(0, 3) != 0)
                  a = 16'(map_r[t][15:0] + $urandom_range(0, 8));
               q = ($urandom_range(0, 7) == 0) ? 16'($urandom) : 16'($urandom_range(0, 12));
               push_req(($urandom_range(0, 1) != 0) ? REQ_OPEN_WR : REQ_OPEN_RD,
                        t, a, q, 16'($urandom));
               n++;
               repeat ($urandom_range(0, 14)) begin
                  push_req(REQ_XFER, 2'($urandom), 16'($urandom), 16'($urandom),
                           16'($urandom));
                  n++;
               end
            end
            5, 6: begin
               a = (map_r[t][31:16] != 0 && $urandom_range(0, 2) != 0) ?
                   16'(map_r[t][15:0] + $urandom_range(0, 20)) : 16'($urandom);
               push_req(REQ_LOCAL, t, a, 16'($urandom), 16'($urandom));
               n++;
            end
            7: begin
               push_req(REQ_CLR, t, 16'($urandom), 16'($urandom), 16'($urandom));
               n++;
            end
            8: begin
               push_req(3'($urandom_range(5, 7)), t, 16'($urandom), 16'($urandom),
                        16'($urandom));
               n++;
            end
            default: begin
               push_req(REQ_XFER, t, 16'($urandom), 16'($urandom), 16'($urandom));
               n++;
            end
         endcase
      end
   endfunction

   initial begin
      csr_ch.valid = 1'b0;
      csr_ch.index = '0;
      csr_ch.wdata = '0;
      for (int i = 0; i < 4; i++) map_r[i] = '0;
      m_mode = MODE_IDLE; m_tbl = '0; m_addr = '0; m_rem = '0; m_dirty = 1'b0;
      for (int i = 0; i < BDEPTH; i++) begin coil_m[i] = 1'b0; disc_m[i] = 1'b0; end
      for (int i = 0; i < WDEPTH; i++) begin inreg_m[i] = '0; hold_m[i] = '0; end
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed: unmapped tables and idle transfers
      push_req(REQ_XFER, TBL_COIL, 16'd0, 16'd0, 16'd0);
      push_req(REQ_OPEN_RD, TBL_HOLD, 16'd0, 16'd0, 16'd0);
      push_req(REQ_CLR, TBL_COIL, 16'd0, 16'd0, 16'd0);
      push_req(3'd7, TBL_HOLD, 16'hffff, 16'hffff, 16'hffff);
      drain();

      write_map(TBL_COIL, seg_pair(16'd10, 16'd4, 16'd14, 16'd1020));
      write_map(TBL_DISC, seg_pair(16'd100, 16'd8, 16'd0, 16'd0));
      write_map(TBL_INREG, seg_pair(16'hfff0, 16'd16, 16'd0, 16'd4));
      write_map(TBL_HOLD, seg_pair(16'd40, 16'd300, 16'd20, 16'd20));

      // directed: spanning segments, read-only, overflow, range past top
      push_req(REQ_LOCAL, TBL_HOLD, 16'd20, 16'd0, 16'hffff);
      push_req(REQ_LOCAL, TBL_DISC, 16'd107, 16'd0, 16'h0001);
      push_req(REQ_LOCAL, TBL_INREG, 16'd50, 16'd0, 16'h1234);
      push_req(REQ_OPEN_WR, TBL_DISC, 16'd100, 16'd1, 16'd0);
      push_req(REQ_OPEN_WR, TBL_INREG, 16'hfff0, 16'd1, 16'd0);
      push_req(REQ_OPEN_RD, TBL_INREG, 16'hfff0, 16'd17, 16'd0);
      push_req(REQ_OPEN_RD, TBL_HOLD, 16'd19, 16'd2, 16'd0);
      push_req(REQ_OPEN_WR, TBL_HOLD, 16'd38, 16'd3, 16'd0);
      push_req(REQ_XFER, TBL_COIL, 16'd0, 16'd0, 16'h8000);
      push_req(REQ_XFER, TBL_COIL, 16'd0, 16'd0, 16'h7fff);
      push_req(REQ_XFER, TBL_COIL, 16'd0, 16'd0, 16'haaaa);
      push_req(REQ_OPEN_RD, TBL_HOLD, 16'd339, 16'd1, 16'd0);
      push_req(REQ_XFER, TBL_COIL, 16'd0, 16'd0, 16'd0);
      push_req(REQ_OPEN_WR, TBL_COIL, 16'd1030, 16'd4, 16'd0);
      push_req(REQ_XFER, TBL_COIL, 16'd0, 16'd0, 16'd1);
      push_req(REQ_OPEN_RD, TBL_COIL, 16'd12, 16'd0, 16'd0);
      push_req(REQ_OPEN_RD, TBL_DISC, 16'd107, 16'd1, 16'd0);
      push_req(REQ_XFER, TBL_COIL, 16'd0, 16'd0, 16'd0);
      push_req(REQ_OPEN_RD, TBL_HOLD, 16'd40, 16'd3, 16'd0);
      push_req(REQ_XFER, TBL_COIL, 16'd0, 16'd0, 16'd0);
      drain();

      // transfer left open across a map change
      write_map(TBL_HOLD, seg_pair(16'd500, 16'd4, 16'd0, 16'd0));
      push_req(REQ_XFER, TBL_HOLD, 16'd0, 16'd0, 16'd0);
      push_req(REQ_CLR, TBL_HOLD, 16'd0, 16'd0, 16'd0);
      drain();

      // long receiver hold-off while requests keep coming
      hold_off = 1'b1;
      random_batch(30);
      repeat (60) @(posedge clock);
      hold_off = 1'b0;
      drain();

      for (int ph = 0; ph < 6; ph++) begin
         for (int t = 0; t < 4; t++) begin
            case (ph)
               0: write_map(t, '1);
               1: write_map(t, seg_pair(16'($urandom_range(0, 200)), 16'($urandom_range(1, 300)),
                                        16'($urandom_range(0, 600)), 16'($urandom_range(0, 800))));
               2: write_map(t, seg_pair(16'd0, 16'd200, 16'd200, 16'd900));
               3: write_map(t, {$urandom, $urandom});
               4: write_map(t, seg_pair(16'd300, 16'd30, 16'd250, 16'd50));
               default: write_map(t, '0);
            endcase
         end
         random_batch(ph == 5 ? 50 : 290);
         drain();
      end

      drain();
      if (errors == 0) $display("modbus_segmented_data_map_core: match");
      else $display("modbus_segmented_data_map_core: mismatch");
      $finish;
   end
endmodule
